// ===== design/car_pkg.sv =====
// Shared types, widths, register codes and reset values for the CIGAR rescoring block.
package car_pkg;

  localparam int CMD_W   = 2;
  localparam int RUN_W   = 16;
  localparam int BASE_W  = 3;
  localparam int SCORE_W = 21;
  localparam int EDITS_W = 16;
  localparam int MAG_W   = 20;  // open + run * extend peaks at 983088
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  // event codes
  localparam logic [CMD_W-1:0] CMD_MATCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INS   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLIP  = 2'd3;

  localparam logic [BASE_W-1:0] BASE_N = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_SCORE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEL_OPEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEL_EXTEND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INS_OPEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INS_EXTEND  = 3'd5;

  typedef struct packed {
    logic [3:0] match_score;
    logic [3:0] mismatch_penalty;
    logic [5:0] del_open;
    logic [3:0] del_extend;
    logic [5:0] ins_open;
    logic [3:0] ins_extend;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    match_score:      4'd1,
    mismatch_penalty: 4'd4,
    del_open:         6'd6,
    del_extend:       4'd1,
    ins_open:         6'd6,
    ins_extend:       4'd1
  };

  // decoded event: signed score change as sign + magnitude, edit increment
  typedef struct packed {
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [EDITS_W-1:0] edit_inc;
    logic               last;
  } evt_t;

endpackage

// ===== design/car_decode.sv =====
// Event decoder: turns one CIGAR event into a score change and an edit increment.
module car_decode (
  input  logic [car_pkg::CMD_W-1:0]  cmd,
  input  logic [car_pkg::RUN_W-1:0]  run_len,
  input  logic [car_pkg::BASE_W-1:0] ref_base,
  input  logic [car_pkg::BASE_W-1:0] query_base,
  input  logic                       reverse,
  input  logic                       last,
  input  car_pkg::cfg_t              cfg,
  output car_pkg::evt_t              evt
);
  import car_pkg::*;

  logic [BASE_W-1:0] rb;
  logic [BASE_W-1:0] qb;
  logic [BASE_W-1:0] qb_fix;
  logic              same;
  logic [3:0]        ext;
  logic [5:0]        opn;
  logic [MAG_W-1:0]  gap_mag;

  // codes above N count as N
  assign rb     = (ref_base > BASE_N) ? BASE_N : ref_base;
  assign qb     = (query_base > BASE_N) ? BASE_N : query_base;
  // complement: A<->T, C<->G is 3 - code, i.e. invert the low two bits
  assign qb_fix = (reverse && qb != BASE_N) ? {1'b0, ~qb[1:0]} : qb;
  assign same   = (rb == qb_fix) && (rb != BASE_N);

  assign ext     = (cmd == CMD_DEL) ? cfg.del_extend : cfg.ins_extend;
  assign opn     = (cmd == CMD_DEL) ? cfg.del_open   : cfg.ins_open;
  assign gap_mag = MAG_W'(run_len) * MAG_W'(ext) + MAG_W'(opn);

  always_comb begin
    evt.last     = last;
    evt.neg      = 1'b0;
    evt.mag      = '0;
    evt.edit_inc = '0;
    case (cmd)
      CMD_MATCH: begin
        if (same) begin
          evt.mag = MAG_W'(cfg.match_score);
        end else begin
          evt.neg      = 1'b1;
          evt.mag      = MAG_W'(cfg.mismatch_penalty);
          evt.edit_inc = EDITS_W'(1);
        end
      end
      CMD_DEL, CMD_INS: begin
        evt.neg      = 1'b1;
        evt.mag      = gap_mag;
        evt.edit_inc = run_len;
      end
      CMD_CLIP: begin
        evt.mag = '0;
      end
      default: begin
        evt.mag = '0;
      end
    endcase
  end

endmodule

// ===== design/car_accum.sv =====
// Saturating score and edit accumulators with the result register.
module car_accum (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               evt_go,
  input  car_pkg::evt_t                      evt,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [car_pkg::SCORE_W-1:0] out_score,
  output logic [car_pkg::EDITS_W-1:0]        out_edits
);
  import car_pkg::*;

  logic signed [SCORE_W-1:0] score_acc_r;
  logic [EDITS_W-1:0]        edit_acc_r;
  logic                      out_valid_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic [EDITS_W-1:0]        out_edits_r;

  logic [SCORE_W:0]          acc_x;
  logic [SCORE_W:0]          mag_x;
  logic [SCORE_W:0]          sum;
  logic signed [SCORE_W-1:0] score_nxt;
  logic [EDITS_W:0]          esum;
  logic [EDITS_W-1:0]        edits_nxt;

  // one guard bit is enough: |acc| <= 2^20 and mag < 2^20
  assign acc_x = {score_acc_r[SCORE_W-1], score_acc_r};
  assign mag_x = (SCORE_W+1)'(evt.mag);
  assign sum   = evt.neg ? (acc_x - mag_x) : (acc_x + mag_x);

  always_comb begin
    case (sum[SCORE_W:SCORE_W-1])
      2'b01:   score_nxt = {1'b0, {(SCORE_W-1){1'b1}}};
      2'b10:   score_nxt = {1'b1, {(SCORE_W-1){1'b0}}};
      default: score_nxt = sum[SCORE_W-1:0];
    endcase
  end

  assign esum      = {1'b0, edit_acc_r} + {1'b0, evt.edit_inc};
  assign edits_nxt = esum[EDITS_W] ? {EDITS_W{1'b1}} : esum[EDITS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_acc_r <= '0;
      edit_acc_r  <= '0;
    end else if (evt_go) begin
      if (evt.last) begin
        score_acc_r <= '0;
        edit_acc_r  <= '0;
      end else begin
        score_acc_r <= score_nxt;
        edit_acc_r  <= edits_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (evt_go && evt.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_go && evt.last) begin
      out_score_r <= score_nxt;
      out_edits_r <= edits_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_score = out_score_r;
  assign out_edits = out_edits_r;

endmodule

// ===== design/cigar_affine_rescore.sv =====
// Top level of the CIGAR affine-gap rescoring block.
//
// Usage: one alignment arrives as a stream of CIGAR event requests on the
// in_ channel (valid/ready). A match event compares ref_base with
// query_base (complemented when reverse is set); deletion and insertion
// events charge open + run_len * extend. The request with in_last set
// closes the alignment: its totals leave on the out_ channel as one
// request (out_score, out_edits) and the accumulators clear.
// Flow: the event is decoded into an event register at acceptance; from
// there it is folded into the accumulators and, for the last event, loads
// the result register, which raises out_valid; a last event waits in the
// event register while an earlier result is still pending.
// Throughput: one event per cycle. Events that produce no result keep
// flowing while a result waits in the output register; only a second last
// event stalls (in_ready low) until the waiting result is taken.
// Configuration: six penalty registers, written through cfg_ (always
// ready); write them only while the block is idle.
// Reset (synchronous, rst_n low): accumulators zero, registers at defaults,
// no result pending.
module cigar_affine_rescore (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // event requests
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [car_pkg::CMD_W-1:0]             in_cmd,
  input  logic [car_pkg::RUN_W-1:0]             in_run_len,
  input  logic [car_pkg::BASE_W-1:0]            in_ref_base,
  input  logic [car_pkg::BASE_W-1:0]            in_query_base,
  input  logic                                  in_reverse,
  input  logic                                  in_last,
  // result requests
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [car_pkg::SCORE_W-1:0]    out_score,
  output logic [car_pkg::EDITS_W-1:0]           out_edits,
  // register writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [car_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [car_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import car_pkg::*;

  cfg_t cfg_r;
  evt_t evt_dec;
  evt_t evt_r;
  logic evt_vld_r;
  logic evt_vld_nxt;
  logic out_free;
  logic evt_go;
  logic in_acc;

  // register file; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MATCH_SCORE: cfg_r.match_score      <= cfg_data[3:0];
        REG_MISMATCH:    cfg_r.mismatch_penalty <= cfg_data[3:0];
        REG_DEL_OPEN:    cfg_r.del_open         <= cfg_data;
        REG_DEL_EXTEND:  cfg_r.del_extend       <= cfg_data[3:0];
        REG_INS_OPEN:    cfg_r.ins_open         <= cfg_data;
        REG_INS_EXTEND:  cfg_r.ins_extend       <= cfg_data[3:0];
        default:         cfg_r                  <= cfg_r;  // unused indexes
      endcase
    end
  end

  car_decode u_decode (
    .cmd        (in_cmd),
    .run_len    (in_run_len),
    .ref_base   (in_ref_base),
    .query_base (in_query_base),
    .reverse    (in_reverse),
    .last       (in_last),
    .cfg        (cfg_r),
    .evt        (evt_dec)
  );

  // event register: a non-last event always drains; a last one waits for
  // the result register to be free
  assign out_free = !out_valid || out_ready;
  assign evt_go   = evt_vld_r && (!evt_r.last || out_free);
  assign in_ready = !evt_vld_r || evt_go;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    if (in_acc) begin
      evt_vld_nxt = 1'b1;
    end else if (evt_go) begin
      evt_vld_nxt = 1'b0;
    end else begin
      evt_vld_nxt = evt_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_vld_r <= 1'b0;
    end else begin
      evt_vld_r <= evt_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      evt_r <= evt_dec;
    end
  end

  car_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_go    (evt_go),
    .evt       (evt_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_score (out_score),
    .out_edits (out_edits)
  );

endmodule

// ===== design/car_checker.sv =====
// Port-level checks for the CIGAR rescoring block, bound to its top level.
module car_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [car_pkg::SCORE_W-1:0] out_score,
  input logic [car_pkg::EDITS_W-1:0]        out_edits
);
  import car_pkg::*;

  // a stalled result holds
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score) && $stable(out_edits))
    else $error("result changed while stalled");

  // reset leaves no result pending
  ap_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // with the result register empty the event stage never backs up
  ap_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a fresh result must be preceded by an accepted event
  ap_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding event");

endmodule

bind cigar_affine_rescore car_checker u_car_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_score (out_score),
  .out_edits (out_edits)
);
